FILE: design/llrb_pkg.sv
// shared constants, codes and types for the leveled log ring buffer
package llrb_pkg;

  // ring geometry (power of two, 16 to 65536)
  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  // characters the prefix logic looks for
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  // input word kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // output word kinds
  localparam logic [1:0] REPLY_ECHO  = 2'd0;
  localparam logic [1:0] REPLY_READ  = 2'd1;
  localparam logic [1:0] REPLY_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CONSOLE_LEVEL = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_LEVEL = 2'd1;
  localparam logic [1:0] CFG_LAYOUT        = 2'd2;

  // layout that keeps an end pointer
  localparam logic [1:0] LAYOUT_END_PTR = 2'd2;

  // write step indexes: three prefix bytes, then up to three text bytes
  localparam logic [2:0] STEP_TEXT0 = 3'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_EMIT
  } state_e;

endpackage

FILE: design/leveled_log_ring_buffer.sv
// leveled log ring buffer: prefix handling, ring writes, reads and echo output
// Sequence: an append is accepted, then its ring writes are made one after another
//   (zero to six, prefix and held text included), then its echo words are offered.
//   A read or clear answers in the cycle after acceptance.
// Throughput: one word at a time; the next word is taken only after the ring writes
//   through the single write port of the ring memory and all echo words are done.
// Reset: pointers, total, line and hold state are cleared at once; ring contents
//   are undefined until written, so there is no clearing pass.
module leveled_log_ring_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_byte_i,
  input  logic        string_end_i,
  input  logic [9:0]  read_offset_i,
  // output words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  reply_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        offset_valid_o,
  output logic [31:0] oldest_pointer_o,
  output logic [31:0] fill_or_end_o,
  output logic [31:0] total_logged_o,
  output logic        run_last_o
);
  import llrb_pkg::*;

  localparam logic [31:0] DEPTH32 = 32'(RING_DEPTH);

  state_e state_q, state_d;

  // configuration registers
  logic [3:0] console_level_q;
  logic [2:0] default_level_q;
  logic [1:0] layout_q;

  // ring pointers
  logic [31:0] oldest_q, fill_q, total_q;

  // line and prefix hold state
  logic       line_open_q;
  logic [2:0] line_level_q;
  logic [1:0] held_cnt_q;
  logic [7:0] held0_q, held1_q;

  // per-word work registers
  logic [7:0] pfx_dig_q;
  logic [7:0] text_q [3];
  logic [2:0] wr_idx_q, wr_end_q;
  logic [1:0] emit_cnt_q, out_idx_q;
  logic [1:0] rkind_q;
  logic       ofs_valid_q;

  // ring memory
  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] rd_data_q;

  logic in_acc, out_acc, wr_en, wr_last, emit_last;
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign wr_last   = (wr_idx_q + 3'd1) == wr_end_q;
  assign emit_last = (out_idx_q + 2'd1) == emit_cnt_q;

  // append decode: prefix, text bytes and new line state
  logic       a_pfx, a_open, a_digit;
  logic [7:0] a_pfx_dig, a_h0, a_h1;
  logic [7:0] a_t [3];
  logic [1:0] a_tcnt, a_hcnt, a_ecnt;
  logic [2:0] a_level;
  logic [7:0] def_char;

  always_comb begin
    def_char  = CH_ZERO + 8'(default_level_q);
    a_digit   = (char_byte_i >= CH_ZERO) && (char_byte_i <= CH_SEVEN);
    a_pfx     = 1'b0;
    a_pfx_dig = def_char;
    a_open    = line_open_q;
    a_level   = line_level_q;
    a_hcnt    = held_cnt_q;
    a_h0      = held0_q;
    a_h1      = held1_q;
    a_tcnt    = 2'd0;
    a_t[0]    = char_byte_i;
    a_t[1]    = char_byte_i;
    a_t[2]    = char_byte_i;
    if (line_open_q) begin
      a_tcnt = 2'd1;
      if (char_byte_i == CH_NL) begin
        a_open = 1'b0;
      end
    end else if (held_cnt_q == 2'd0 && char_byte_i == CH_LT) begin
      a_h0   = char_byte_i;
      a_hcnt = 2'd1;
      if (string_end_i) begin
        a_pfx   = 1'b1;
        a_tcnt  = 2'd1;
        a_open  = 1'b1;
        a_level = default_level_q;
        a_hcnt  = 2'd0;
      end
    end else if (held_cnt_q == 2'd1 && a_digit) begin
      a_h1   = char_byte_i;
      a_hcnt = 2'd2;
      if (string_end_i) begin
        a_pfx   = 1'b1;
        a_t[0]  = held0_q;
        a_tcnt  = 2'd2;
        a_open  = 1'b1;
        a_level = default_level_q;
        a_hcnt  = 2'd0;
      end
    end else if (held_cnt_q == 2'd2 && char_byte_i == CH_GT) begin
      // complete prefix: store it as given, nothing echoed
      a_pfx     = 1'b1;
      a_pfx_dig = held1_q;
      a_level   = held1_q[2:0];
      a_open    = 1'b1;
      a_hcnt    = 2'd0;
    end else begin
      // prefix missing: default prefix, held bytes, then this byte
      a_pfx   = 1'b1;
      a_level = default_level_q;
      a_hcnt  = 2'd0;
      a_open  = (char_byte_i != CH_NL);
      case (held_cnt_q)
        2'd0: begin
          a_tcnt = 2'd1;
        end
        2'd1: begin
          a_t[0] = held0_q;
          a_tcnt = 2'd2;
        end
        default: begin
          a_t[0] = held0_q;
          a_t[1] = held1_q;
          a_tcnt = 2'd3;
        end
      endcase
    end
    a_ecnt = ({1'b0, a_level} < console_level_q) ? a_tcnt : 2'd0;
  end

  // read decode: clamped size check and ring address
  logic [31:0]        rd_size;
  logic               rd_ok;
  logic [RING_AW-1:0] rd_addr;

  always_comb begin
    rd_size = (layout_q == LAYOUT_END_PTR) ? (fill_q - oldest_q) : fill_q;
    rd_ok   = ({22'd0, read_offset_i} < rd_size) && ({22'd0, read_offset_i} < DEPTH32);
    rd_addr = oldest_q[RING_AW-1:0] + RING_AW'(read_offset_i);
  end

  // ring write step: address, data and pointer advance
  logic [RING_AW-1:0] wr_addr;
  logic [7:0]         wr_byte;
  logic [31:0]        oldest_w, fill_w, fill_inc, oldest_sum;

  always_comb begin
    fill_inc   = fill_q + 32'd1;
    oldest_sum = oldest_q + fill_q;
    oldest_w   = oldest_q;
    fill_w     = fill_q;
    if (layout_q == LAYOUT_END_PTR) begin
      wr_addr = fill_q[RING_AW-1:0];
      fill_w  = fill_inc;
      if ((fill_inc - oldest_q) > DEPTH32) begin
        oldest_w = oldest_q + 32'd1;
      end
    end else begin
      wr_addr = oldest_sum[RING_AW-1:0];
      if (fill_q < DEPTH32) begin
        fill_w = fill_inc;
      end else begin
        oldest_w = oldest_q + 32'd1;
      end
    end
    case (wr_idx_q)
      3'd0:    wr_byte = CH_LT;
      3'd1:    wr_byte = pfx_dig_q;
      3'd2:    wr_byte = CH_GT;
      3'd3:    wr_byte = text_q[0];
      3'd4:    wr_byte = text_q[1];
      default: wr_byte = text_q[2];
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_READ || kind_i == KIND_CLEAR) begin
            state_d = S_EMIT;
          end else if (kind_i == KIND_APPEND && (a_pfx || a_tcnt != 2'd0)) begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (wr_last) begin
          state_d = (emit_cnt_q != 2'd0) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_acc && emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // handshake and write enable
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    wr_en       = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o  = 1'b1;
      S_WRITE: wr_en       = 1'b1;
      S_EMIT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // output word
  always_comb begin
    reply_kind_o     = rkind_q;
    offset_valid_o   = 1'b0;
    data_byte_o      = 8'd0;
    oldest_pointer_o = oldest_q;
    fill_or_end_o    = fill_q;
    total_logged_o   = total_q;
    run_last_o       = emit_last;
    if (rkind_q == REPLY_READ) begin
      offset_valid_o = ofs_valid_q;
      data_byte_o    = ofs_valid_q ? rd_data_q : 8'd0;
    end else if (rkind_q == REPLY_ECHO) begin
      case (out_idx_q)
        2'd0:    data_byte_o = text_q[0];
        2'd1:    data_byte_o = text_q[1];
        default: data_byte_o = text_q[2];
      endcase
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_byte;
    end
    if (in_acc && kind_i == KIND_READ) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  // per-word work registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pfx_dig_q <= a_pfx_dig;
      text_q[0] <= a_t[0];
      text_q[1] <= a_t[1];
      text_q[2] <= a_t[2];
      wr_end_q  <= STEP_TEXT0 + 3'(a_tcnt);
      ofs_valid_q <= rd_ok;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      console_level_q <= 4'd3;
      default_level_q <= 3'd4;
      layout_q        <= 2'd1;
      oldest_q        <= 32'd0;
      fill_q          <= 32'd0;
      total_q         <= 32'd0;
      line_open_q     <= 1'b0;
      line_level_q    <= 3'd0;
      held_cnt_q      <= 2'd0;
      held0_q         <= 8'd0;
      held1_q         <= 8'd0;
      wr_idx_q        <= 3'd0;
      emit_cnt_q      <= 2'd0;
      out_idx_q       <= 2'd0;
      rkind_q         <= REPLY_ECHO;
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CONSOLE_LEVEL: console_level_q <= cfg_data_i;
          CFG_DEFAULT_LEVEL: default_level_q <= cfg_data_i[2:0];
          CFG_LAYOUT:        layout_q        <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      // word acceptance
      if (in_acc) begin
        out_idx_q <= 2'd0;
        case (kind_i)
          KIND_APPEND: begin
            line_open_q  <= a_open;
            line_level_q <= a_level;
            held_cnt_q   <= a_hcnt;
            held0_q      <= a_h0;
            held1_q      <= a_h1;
            wr_idx_q     <= a_pfx ? 3'd0 : STEP_TEXT0;
            emit_cnt_q   <= a_ecnt;
            rkind_q      <= REPLY_ECHO;
          end
          KIND_READ: begin
            emit_cnt_q <= 2'd1;
            rkind_q    <= REPLY_READ;
          end
          KIND_CLEAR: begin
            oldest_q   <= 32'd0;
            fill_q     <= 32'd0;
            total_q    <= 32'd0;
            emit_cnt_q <= 2'd1;
            rkind_q    <= REPLY_CLEAR;
          end
          default: ;
        endcase
      end
      // ring write step
      if (wr_en) begin
        oldest_q <= oldest_w;
        fill_q   <= fill_w;
        total_q  <= total_q + 32'd1;
        wr_idx_q <= wr_idx_q + 3'd1;
      end
      // result delivery
      if (out_acc) begin
        out_idx_q <= out_idx_q + 2'd1;
      end
    end
  end

  // checks on sequencing
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd3)
    else $error("held prefix count out of range");

  a_write_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (wr_idx_q < wr_end_q))
    else $error("ring write step past end");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_idx_q < emit_cnt_q))
    else $error("result index past count");

  a_ptr_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(out_valid_o)) |-> $stable(total_q))
    else $error("total changed while results drain");

endmodule

FILE: dv/log_ring_checker.sv
// checker for the leveled log ring buffer: predicts reply words and compares them
module log_ring_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_byte_i,
  input  logic        string_end_i,
  input  logic [9:0]  read_offset_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  reply_kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        offset_valid_i,
  input  logic [31:0] oldest_pointer_i,
  input  logic [31:0] fill_or_end_i,
  input  logic [31:0] total_logged_i,
  input  logic        run_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import llrb_pkg::*;

  // register values after reset
  localparam logic [3:0] RST_CONSOLE = 4'd3;
  localparam logic [2:0] RST_DEFAULT = 3'd4;
  localparam logic [1:0] RST_LAYOUT  = 2'd1;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        ok;
    logic [31:0] head;
    logic [31:0] fill;
    logic [31:0] total;
    logic        last;
  } log_word_t;

  // predicted ring and pointers
  logic [7:0]  ring_copy [RING_DEPTH];
  logic [31:0] head_ptr;
  logic [31:0] fill_ptr;
  logic [31:0] logged_total;
  logic [3:0]  line_lvl;
  logic        line_open;
  logic [7:0]  held [2];
  int          held_n;

  // register copies
  logic [3:0]  cons_lvl;
  logic [2:0]  dflt_lvl;
  logic [1:0]  layout;

  // words of the current input, then words still owed by the block
  log_word_t   item_words[$];
  log_word_t   replies_due[$];
  int          fails;

  task automatic add_reply(input logic [1:0] kind, input logic [7:0] data, input logic ok);
    log_word_t w;
    w = '0;
    w.kind = kind;
    w.data = data;
    w.ok   = ok;
    item_words.push_back(w);
  endtask

  // one byte into the ring, overwriting the oldest when full
  task automatic ring_write(input logic [7:0] c);
    logic [31:0] sum;
    if (layout == LAYOUT_END_PTR) begin
      ring_copy[fill_ptr[RING_AW-1:0]] = c;
      fill_ptr = fill_ptr + 32'd1;
      if (fill_ptr - head_ptr > RING_DEPTH) head_ptr = head_ptr + 32'd1;
    end else begin
      sum = head_ptr + fill_ptr;
      ring_copy[sum[RING_AW-1:0]] = c;
      if (fill_ptr < RING_DEPTH) fill_ptr = fill_ptr + 32'd1;
      else head_ptr = head_ptr + 32'd1;
    end
    logged_total = logged_total + 32'd1;
  endtask

  // text byte of an open line: store, echo by level, close at newline
  task automatic store_text(input logic [7:0] c);
    ring_write(c);
    if (line_lvl < cons_lvl) add_reply(REPLY_ECHO, c, 1'b0);
    if (c == CH_NL) line_open = 1'b0;
  endtask

  // missing prefix: insert the default one, held bytes become text
  task automatic open_default_line();
    ring_write(CH_LT);
    ring_write(CH_ZERO + {5'd0, dflt_lvl});
    ring_write(CH_GT);
    line_lvl  = {1'b0, dflt_lvl};
    line_open = 1'b1;
    for (int i = 0; i < held_n; i++) store_text(held[i]);
    held_n = 0;
  endtask

  task automatic take_char(input logic [7:0] c, input logic se);
    logic [7:0] dig;
    if (line_open) begin
      store_text(c);
    end else if (held_n == 0 && c == CH_LT) begin
      held[0] = c;
      held_n  = 1;
      if (se) open_default_line();
    end else if (held_n == 1 && c >= CH_ZERO && c <= CH_SEVEN) begin
      held[1] = c;
      held_n  = 2;
      if (se) open_default_line();
    end else if (held_n == 2 && c == CH_GT) begin
      ring_write(CH_LT);
      ring_write(held[1]);
      ring_write(CH_GT);
      dig       = held[1] - CH_ZERO;
      line_lvl  = {1'b0, dig[2:0]};
      line_open = 1'b1;
      held_n    = 0;
    end else begin
      open_default_line();
      store_text(c);
    end
  endtask

  task automatic read_ring(input logic [9:0] off);
    logic [31:0] span;
    logic [31:0] sum;
    span = (layout == LAYOUT_END_PTR) ? fill_ptr - head_ptr : fill_ptr;
    if (span > RING_DEPTH) span = RING_DEPTH;
    if ({22'd0, off} < span) begin
      sum = head_ptr + {22'd0, off};
      add_reply(REPLY_READ, ring_copy[sum[RING_AW-1:0]], 1'b1);
    end else begin
      add_reply(REPLY_READ, 8'h00, 1'b0);
    end
  endtask

  // predict every word one accepted input causes
  task automatic predict_item();
    log_word_t w;
    case (kind_i)
      KIND_APPEND: take_char(char_byte_i, string_end_i);
      KIND_READ:   read_ring(read_offset_i);
      KIND_CLEAR: begin
        head_ptr     = '0;
        fill_ptr     = '0;
        logged_total = '0;
        add_reply(REPLY_CLEAR, 8'h00, 1'b0);
      end
      default: ;
    endcase
    // pointers are reported as they stand after the whole input
    for (int k = 0; k < item_words.size(); k++) begin
      w       = item_words[k];
      w.head  = head_ptr;
      w.fill  = fill_ptr;
      w.total = logged_total;
      w.last  = (k == item_words.size() - 1);
      replies_due.push_back(w);
    end
    item_words.delete();
  endtask

  task automatic check_reply();
    log_word_t got;
    log_word_t want;
    got = {reply_kind_i, data_byte_i, offset_valid_i, oldest_pointer_i,
           fill_or_end_i, total_logged_i, run_last_i};
    if (replies_due.size() == 0) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("unexpected word: kind %0d data %h valid %b oldest %h fill %h total %h",
                 got.kind, got.data, got.ok, got.head, got.fill, got.total);
    end else begin
      want = replies_due.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display({"word mismatch (exp/got): kind %0d/%0d data %h/%h valid %b/%b",
                    " oldest %h/%h fill %h/%h total %h/%h last %b/%b"},
                   want.kind, got.kind, want.data, got.data, want.ok, got.ok,
                   want.head, got.head, want.fill, got.fill,
                   want.total, got.total, want.last, got.last);
      end
    end
  endtask

  // output side first: a word seen now never belongs to an input taken now
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr     = '0;
      fill_ptr     = '0;
      logged_total = '0;
      line_lvl     = '0;
      line_open    = 1'b0;
      held[0]      = '0;
      held[1]      = '0;
      held_n       = 0;
      cons_lvl     = RST_CONSOLE;
      dflt_lvl     = RST_DEFAULT;
      layout       = RST_LAYOUT;
      fails        = 0;
      item_words.delete();
      replies_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_reply();
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CONSOLE_LEVEL: cons_lvl = cfg_data_i;
          CFG_DEFAULT_LEVEL: dflt_lvl = cfg_data_i[2:0];
          CFG_LAYOUT:        layout   = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_item();
      fail_count_o <= fails;
      pending_o    <= replies_due.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// top of the leveled log ring buffer testbench: clock, reset, stimulus and verdict
module tb_top;
  import llrb_pkg::*;

  localparam int         LIMIT       = 400000;
  localparam int         SETTLE      = 16;
  localparam logic [1:0] LAYOUT_SIZE = 2'd1;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  char_byte;
  logic        string_end;
  logic [9:0]  read_offset;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  reply_kind;
  logic [7:0]  data_byte;
  logic        offset_valid;
  logic [31:0] oldest_pointer;
  logic [31:0] fill_or_end;
  logic [31:0] total_logged;
  logic        run_last;
  int          fail_count;
  int          pending;

  int          cycles = 0;
  int          items = 0;
  int          rx_hold = 0;
  bit          rx_steady = 1'b0;
  bit          tx_steady = 1'b0;
  bit          wrap_mode = 1'b0;

  leveled_log_ring_buffer uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .char_byte_i      (char_byte),
    .string_end_i     (string_end),
    .read_offset_i    (read_offset),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .reply_kind_o     (reply_kind),
    .data_byte_o      (data_byte),
    .offset_valid_o   (offset_valid),
    .oldest_pointer_o (oldest_pointer),
    .fill_or_end_o    (fill_or_end),
    .total_logged_o   (total_logged),
    .run_last_o       (run_last)
  );

  log_ring_checker ring_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .kind_i           (kind),
    .char_byte_i      (char_byte),
    .string_end_i     (string_end),
    .read_offset_i    (read_offset),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .reply_kind_i     (reply_kind),
    .data_byte_i      (data_byte),
    .offset_valid_i   (offset_valid),
    .oldest_pointer_i (oldest_pointer),
    .fill_or_end_i    (fill_or_end),
    .total_logged_i   (total_logged),
    .run_last_i       (run_last),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(9, 0) != 0) return int'($urandom_range(3, 1));
    return int'($urandom_range(40, 10));
  endfunction

  function automatic logic [7:0] rnd8();
    logic [31:0] r;
    r = $urandom();
    return r[7:0];
  endfunction

  function automatic logic [9:0] rnd10();
    logic [31:0] r;
    r = $urandom();
    return r[9:0];
  endfunction

  function automatic logic rnd1();
    logic [31:0] r;
    r = $urandom();
    return r[0];
  endfunction

  // receiver stalls, with steady stretches
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (rx_steady || $urandom_range(9, 0) < 7) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      rx_hold   <= idle_len() - 1;
    end
    if (cycles % 256 == 0) rx_steady <= ($urandom_range(3, 0) == 0);
  end

  // one input word; returns on the edge that accepts it, valid left high
  task automatic send_word(input logic [1:0] k, input logic [7:0] c, input logic se,
                           input logic [9:0] off);
    int gap;
    gap = (tx_steady || $urandom_range(99, 0) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    char_byte   <= c;
    string_end  <= se;
    read_offset <= off;
    do @(posedge clk); while (!in_ready);
    if (k != KIND_NONE) items++;
  endtask

  task automatic send_append(input logic [7:0] c, input logic se);
    send_word(KIND_APPEND, c, se, rnd10());
  endtask

  task automatic send_read(input logic [9:0] off);
    send_word(KIND_READ, rnd8(), rnd1(), off);
  endtask

  // stop sending until every owed word is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] con, input logic [2:0] dl, input logic [1:0] lay);
    write_reg(CFG_CONSOLE_LEVEL, con);
    write_reg(CFG_DEFAULT_LEVEL, {1'b0, dl});
    write_reg(CFG_LAYOUT, {2'b00, lay});
  endtask

  // append, with reads, clears, ignored words and pauses mixed in
  task automatic send_mixed(input logic [7:0] c, input logic se);
    int r;
    r = int'($urandom_range(99, 0));
    if (wrap_mode) begin
      if (r < 3) send_read(rnd10());
    end else if (r < 7) begin
      send_read(rnd1() ? {2'd0, rnd8() % 8'd32} : rnd10());
    end else if (r < 9) begin
      send_word(KIND_CLEAR, rnd8(), rnd1(), rnd10());
    end else if (r < 11) begin
      send_word(KIND_NONE, rnd8(), rnd1(), rnd10());
    end else if (r == 11) begin
      drain();
    end
    send_append(c, se);
  endtask

  // one log line: well-formed prefix mostly, some missing, cut or broken
  task automatic emit_line();
    int style;
    int len;
    logic [31:0] r;
    if ($urandom_range(15, 0) == 0) tx_steady = ($urandom_range(2, 0) == 0);
    style = int'($urandom_range(9, 0));
    if (wrap_mode && $urandom_range(19, 0) != 0) begin
      // bare newline: four ring writes per word while no line is open
      send_mixed(CH_NL, rnd1());
    end else begin
      r = $urandom_range(7, 0);
      if (style < 5) begin
        send_mixed(CH_LT, 1'b0);
        send_mixed(CH_ZERO + r[7:0], 1'b0);
        send_mixed(CH_GT, 1'b0);
      end else if (style == 7) begin
        send_mixed(CH_LT, rnd1());
      end else if (style == 8) begin
        send_mixed(CH_LT, 1'b0);
        send_mixed(CH_ZERO + r[7:0], rnd1());
      end else if (style == 9) begin
        len = int'($urandom_range(4, 1));
        for (int i = 0; i < len; i++) send_mixed(rnd8(), rnd1());
      end
      len = int'($urandom_range(6, 0));
      for (int i = 0; i < len; i++) send_mixed(rnd8(), ($urandom_range(9, 0) == 0));
      if ($urandom_range(9, 0) != 0) send_mixed(CH_NL, rnd1());
    end
  endtask

  task automatic run_phase(input logic [3:0] con, input logic [2:0] dl, input logic [1:0] lay,
                           input int target, input bit wrap);
    int start;
    drain();
    set_config(con, dl, lay);
    wrap_mode = wrap;
    tx_steady = ($urandom_range(3, 0) == 0);
    start = items;
    while (items - start < target) emit_line();
  endtask

  // stimulus
  initial begin
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_CONSOLE_LEVEL;
    cfg_data    = '0;
    in_valid    = 1'b0;
    kind        = KIND_APPEND;
    char_byte   = '0;
    string_end  = 1'b0;
    read_offset = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: echo everything, default level zero
    set_config(4'd8, 3'd0, LAYOUT_SIZE);
    send_read(10'd0);
    send_append(8'h41, 1'b0);
    send_append(8'h00, 1'b0);
    send_append(CH_NL, 1'b0);
    send_append(CH_LT, 1'b0);
    send_append(CH_SEVEN, 1'b0);
    send_append(CH_GT, 1'b0);
    send_append(8'hFF, 1'b0);
    send_append(8'h78, 1'b0);
    send_append(CH_NL, 1'b1);
    // prefix mismatch on the third byte: three echoes
    send_append(CH_LT, 1'b0);
    send_append(8'h33, 1'b0);
    send_append(8'h71, 1'b0);
    send_append(CH_NL, 1'b0);
    // prefix cut by string end after one and after two bytes
    send_append(CH_LT, 1'b1);
    send_append(CH_NL, 1'b0);
    send_append(CH_LT, 1'b0);
    send_append(8'h35, 1'b1);
    send_append(CH_NL, 1'b0);
    send_read(10'd0);
    send_read(10'd1023);
    send_read(10'd5);
    send_word(KIND_NONE, 8'hFF, 1'b1, 10'd1023);
    send_word(KIND_CLEAR, 8'h00, 1'b0, 10'd0);
    send_read(10'd0);

    // end pointer layout, enough newlines to wrap the ring
    run_phase(4'd0, 3'd7, LAYOUT_END_PTR, 330, 1'b1);
    // end pointer beyond depth read back as a size
    run_phase(4'd8, 3'd7, LAYOUT_SIZE, 30, 1'b0);
    run_phase(4'd5, 3'd3, LAYOUT_END_PTR, 30, 1'b0);
    r0 = $urandom_range(8, 0);
    r1 = $urandom_range(7, 0);
    r2 = $urandom_range(2, 1);
    run_phase(r0[3:0], r1[2:0], r2[1:0], 30, 1'b0);
    run_phase(4'd3, 3'd4, LAYOUT_SIZE, 30, 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: leveled_log_ring_buffer.f
design/llrb_pkg.sv
design/leveled_log_ring_buffer.sv
dv/log_ring_checker.sv
dv/tb_top.sv
